// ===== rtl/ngp_pkg.sv =====
// package: shared constants, types and tables of the gga sentence parser
`default_nettype none
package ngp_pkg;
    localparam int MAX_LINE    = 256;
    localparam int FIELD_CHARS = 16;
    localparam int SLOT_BYTES  = 16;
    localparam int CHARS_LIM   = (FIELD_CHARS < SLOT_BYTES) ? FIELD_CHARS : SLOT_BYTES;
    localparam int CONTENT_MAX = MAX_LINE - 3;
    localparam int LC_W        = $clog2(CONTENT_MAX + 2);
    localparam int LEN_W       = $clog2(CHARS_LIM + 1);
    // two banks of eight slots, slot seven of each bank unused
    localparam int STORE_DEPTH = 2 * 8 * SLOT_BYTES;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_LF     = 8'h0A;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_NOT_GGA = 3'd1, ST_NO_STAR = 3'd2,
        ST_CHECKSUM = 3'd3, ST_FEW_FIELDS = 3'd4, ST_TOO_LONG = 3'd5
    } t_status;

    localparam logic [2:0] ID_SUMMARY = 3'd7;
    localparam logic [2:0] NO_SLOT    = 3'd7;

    // line summary handed from front to back at a line end
    typedef struct packed {
        t_status           status;
        logic [6:0][LEN_W-1:0] lengths;
        logic [7:0]        ns;
        logic [7:0]        ew;
        logic [7:0]        unit;
        logic              bank;
    } t_line;

    typedef struct packed {
        logic [2:0]  field_id;
        logic        chunk_index;
        logic [63:0] chunk_text;
        logic [3:0]  chunk_length;
        logic [7:0]  ns_char;
        logic [7:0]  ew_char;
        logic [7:0]  unit_char;
        logic        fix_valid;
        logic [2:0]  status;
        logic        last;
    } t_result;

    typedef enum logic [1:0] { BK_IDLE, BK_READ, BK_EMIT } t_back_state;

    function automatic logic [2:0] text_slot(input logic [3:0] f);
        logic [2:0] s;
        unique case (f)
            4'd1: s = 3'd0;
            4'd2: s = 3'd1;
            4'd4: s = 3'd2;
            4'd6: s = 3'd3;
            4'd7: s = 3'd4;
            4'd8: s = 3'd5;
            4'd9: s = 3'd6;
            default: s = NO_SLOT;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] ind_slot(input logic [3:0] f);
        logic [1:0] s;
        unique case (f)
            4'd3:  s = 2'd0;
            4'd5:  s = 2'd1;
            4'd10: s = 2'd2;
            default: s = 2'd3;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] hdr_char(input logic [2:0] p);
        logic [7:0] c;
        unique case (p)
            3'd0: c = 8'h24;
            3'd1: c = 8'h47;
            3'd2: c = 8'h50;
            3'd3: c = 8'h47;
            3'd4: c = 8'h47;
            3'd5: c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/ngp_stream_if.sv =====
// interface: valid/ready channel carrying one payload
`default_nettype none
interface ngp_stream_if #(parameter type T = logic [7:0]);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/nmea_gga_sentence_parser.sv =====
// top level: gga sentence parser, front scan, summary queue, field store, back emit
//  channel   dir  payload                               transaction when
//  i_rx      in   rx_byte[7:0]                          valid && ready
//  o_res     out  field_id..last (ngp_pkg::t_result)    valid && ready
// one byte a cycle; at cr lf the front waits until the back has finished the
// previous line; the store has two banks, one filled while the other is read
// a cr followed by a byte other than lf is taken on its own, and that byte waits
// an accepted line needs the back part to read and emit every chunk, a rejected one only its summary
// reset clears front line state, queue pointers and back state; the store and back data registers need no clearing
// a stalled result output holds the back part; the front keeps taking bytes up to the next line end
`default_nettype none
module nmea_gga_sentence_parser (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ngp_stream_if.sink   i_rx,
    ngp_stream_if.source o_res
);
    logic we;
    logic [ngp_pkg::STORE_AW-1:0] waddr, raddr;
    logic [7:0] wdata, rdata;
    logic fl_valid, q_ready, q_valid, pop, busy;
    ngp_pkg::t_line fl, ql;

    ngp_front u_front (
        .i_clk, .i_rst_n, .i_valid(i_rx.valid), .i_byte(i_rx.data), .o_ready(i_rx.ready),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata), .o_line_valid(fl_valid),
        .o_line(fl), .i_line_ready(q_ready), .i_back_busy(busy)
    );
    ngp_queue u_queue (
        .i_clk, .i_rst_n, .i_push(fl_valid), .i_data(fl), .o_ready(q_ready),
        .o_valid(q_valid), .o_data(ql), .i_pop(pop)
    );
    ngp_ram #(.WIDTH(8), .DEPTH(ngp_pkg::STORE_DEPTH)) u_store (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata), .i_raddr(raddr), .o_rdata(rdata)
    );
    ngp_back u_back (
        .i_clk, .i_rst_n, .i_line_valid(q_valid), .i_line(ql), .o_pop(pop), .o_busy(busy),
        .o_raddr(raddr), .i_rdata(rdata), .o_res(o_res)
    );
endmodule
`default_nettype wire

// ===== rtl/ngp_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none
module ngp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/ngp_front.sv =====
// front: byte scanning, checksum, field capture, line summary into the queue
`default_nettype none
module ngp_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [7:0]                i_byte,
    output logic                           o_ready,
    output logic                           o_we,
    output logic [ngp_pkg::STORE_AW-1:0]   o_waddr,
    output logic [7:0]                     o_wdata,
    output logic                           o_line_valid,
    output ngp_pkg::t_line                 o_line,
    input  wire logic                      i_line_ready,
    input  wire logic                      i_back_busy
);
    logic [ngp_pkg::LC_W-1:0] r_lc, n_lc;
    logic [2:0] r_hp, n_hp;
    logic [7:0] r_xor, n_xor, r_sum, n_sum;
    logic r_star, n_star, r_cr, n_cr, r_long, n_long;
    logic r_bank, n_bank;
    logic [1:0] r_hex, n_hex;
    logic [3:0] r_fn, n_fn;
    logic [1:0] r_fc, n_fc;
    logic [6:0][ngp_pkg::LEN_W-1:0] r_len, n_len;
    logic [2:0][7:0] r_ind, n_ind;

    logic acc, eol, take, flush;
    logic [7:0] b;
    logic [2:0] ts;
    logic [1:0] is;
    logic [3:0] hv;
    logic hok;
    ngp_pkg::t_status st;

    // a held cr not followed by lf is taken on its own, the new byte waits
    assign flush   = r_cr && i_valid && i_byte != ngp_pkg::C_LF;
    // a line end waits while the queue is full or the back part still reads the other bank
    assign o_ready = !flush &&
                     !(r_cr && i_byte == ngp_pkg::C_LF && (!i_line_ready || i_back_busy));
    assign acc  = i_valid && o_ready;
    assign eol  = acc && r_cr && i_byte == ngp_pkg::C_LF;

    always_comb begin
        if (r_long) st = ngp_pkg::ST_TOO_LONG;
        else if (r_hp != 3'd6) st = ngp_pkg::ST_NOT_GGA;
        else if (!r_star) st = ngp_pkg::ST_NO_STAR;
        else if (r_hex != 2'd2 || r_sum != r_xor) st = ngp_pkg::ST_CHECKSUM;
        else if (r_fn < 4'd10) st = ngp_pkg::ST_FEW_FIELDS;
        else st = ngp_pkg::ST_OK;
    end
    assign o_line_valid   = eol;
    assign o_line.status  = st;
    assign o_line.lengths = r_len;
    assign o_line.ns      = r_ind[0];
    assign o_line.ew      = r_ind[1];
    assign o_line.unit    = r_ind[2];
    assign o_line.bank    = r_bank;

    // the byte taken this cycle: the held cr on a flush cycle, else the new byte
    always_comb begin
        b    = flush ? ngp_pkg::C_CR : i_byte;
        take = flush || (acc && !eol && i_byte != ngp_pkg::C_CR);
        ts   = ngp_pkg::text_slot(r_fn);
        is   = ngp_pkg::ind_slot(r_fn);
        hok  = 1'b1;
        hv   = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) hv = 4'(b - 8'h30);
        else if (b >= 8'h41 && b <= 8'h46) hv = 4'(b - 8'h37);
        else if (b >= 8'h61 && b <= 8'h66) hv = 4'(b - 8'h57);
        else hok = 1'b0;
    end

    always_comb begin
        n_lc = r_lc; n_hp = r_hp; n_xor = r_xor; n_sum = r_sum; n_star = r_star;
        n_hex = r_hex; n_fn = r_fn; n_fc = r_fc; n_len = r_len; n_ind = r_ind;
        n_long = r_long; n_cr = r_cr; n_bank = r_bank;
        o_we = 1'b0; o_waddr = '0; o_wdata = b;
        if (flush) n_cr = 1'b0;
        else if (acc) n_cr = !eol && (i_byte == ngp_pkg::C_CR);
        if (take) begin
            if (r_lc <= ngp_pkg::LC_W'(ngp_pkg::CONTENT_MAX)) n_lc = r_lc + 1'b1;
            if (n_lc > ngp_pkg::LC_W'(ngp_pkg::CONTENT_MAX)) n_long = 1'b1;
            if (r_hp < 3'd6) n_hp = (b == ngp_pkg::hdr_char(r_hp)) ? r_hp + 3'd1 : 3'd7;
            if (!r_star) begin
                if (b == ngp_pkg::C_STAR) n_star = 1'b1;
                else begin
                    if (r_lc != '0) n_xor = r_xor ^ b;
                    if (b == ngp_pkg::C_COMMA) begin
                        if (r_fn < 4'd15) n_fn = r_fn + 4'd1;
                        n_fc = 2'd0;
                    end else begin
                        if (ts != ngp_pkg::NO_SLOT &&
                            r_len[ts] < ngp_pkg::LEN_W'(ngp_pkg::CHARS_LIM)) begin
                            o_we = 1'b1;
                            o_waddr = ngp_pkg::STORE_AW'({r_bank, ts} * ngp_pkg::SLOT_BYTES)
                                    + ngp_pkg::STORE_AW'(r_len[ts]);
                            n_len[ts] = r_len[ts] + 1'b1;
                        end
                        if (is != 2'd3 && r_fc == 2'd0) n_ind[is] = b;
                        if (r_fc < 2'd2) n_fc = r_fc + 2'd1;
                    end
                end
            end else if (r_hex < 2'd2 && hok) begin
                n_sum = {r_sum[3:0], hv};
                n_hex = r_hex + 2'd1;
            end else n_hex = 2'd3;
        end
        if (eol) begin
            n_lc = '0; n_hp = '0; n_xor = '0; n_sum = '0; n_star = 1'b0; n_hex = '0;
            n_fn = '0; n_fc = '0; n_len = '0; n_ind = '0; n_long = 1'b0;
            n_bank = !r_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc <= '0; r_hp <= '0; r_xor <= '0; r_sum <= '0; r_star <= 1'b0;
            r_hex <= '0; r_fn <= '0; r_fc <= '0; r_len <= '0; r_ind <= '0;
            r_long <= 1'b0; r_cr <= 1'b0; r_bank <= 1'b0;
        end else begin
            r_lc <= n_lc; r_hp <= n_hp; r_xor <= n_xor; r_sum <= n_sum; r_star <= n_star;
            r_hex <= n_hex; r_fn <= n_fn; r_fc <= n_fc; r_len <= n_len; r_ind <= n_ind;
            r_long <= n_long; r_cr <= n_cr; r_bank <= n_bank;
        end
    end

    a_eol_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_line_valid |-> i_line_ready && !i_back_busy)
        else $error("line end taken without queue room");
    a_clear_after_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_line_valid |=> r_lc == '0 && !r_star && r_fn == '0)
        else $error("line state not cleared");
    a_no_write_after_star: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> !r_star)
        else $error("store written after star");
endmodule
`default_nettype wire

// ===== rtl/ngp_queue.sv =====
// queue: small fifo of line summaries between front and back
`default_nettype none
module ngp_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  ngp_pkg::t_line    i_data,
    output logic              o_ready,
    output logic              o_valid,
    output ngp_pkg::t_line    o_data,
    input  wire logic         i_pop
);
    ngp_pkg::t_line r_q [ngp_pkg::QUEUE_DEPTH];
    logic [ngp_pkg::QUEUE_AW-1:0] r_wp, r_rp;
    logic [ngp_pkg::QUEUE_AW:0] r_cnt;
    logic push, pop;
    assign o_ready = r_cnt != (ngp_pkg::QUEUE_AW+1)'(ngp_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_q[r_rp];
    assign push = i_push && o_ready;
    assign pop  = i_pop && o_valid;
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_data;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ngp_back.sv =====
// back: reads the field store and emits chunk and summary results
`default_nettype none
module ngp_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_line_valid,
    input  ngp_pkg::t_line                 i_line,
    output logic                           o_pop,
    output logic                           o_busy,
    output logic [ngp_pkg::STORE_AW-1:0]   o_raddr,
    input  wire logic [7:0]                i_rdata,
    ngp_stream_if.source                   o_res
);
    ngp_pkg::t_back_state r_st, n_st;
    logic [3:0] r_ei, n_ei;          // result number, 14 is the summary
    logic [4:0] r_ci, n_ci;          // byte read pointer within the chunk
    logic [63:0] r_txt, n_txt;
    logic r_fix, n_fix, r_fdone, n_fdone, r_neg, n_neg, r_lead, n_lead;
    ngp_pkg::t_result r_out, n_out;
    logic r_ov, n_ov;
    logic [2:0] f;
    logic [ngp_pkg::LEN_W-1:0] flen;
    logic [4:0] start, n_chars, nb;
    logic [3:0] j;
    logic ok, bvalid;

    assign f     = r_ei[3:1];
    assign ok    = i_line.status == ngp_pkg::ST_OK;
    assign flen  = i_line.lengths[(f > 3'd6) ? 3'd6 : f];
    assign start = {r_ei[0], 3'b000};
    assign n_chars = (5'(flen) > start) ? ((5'(flen) - start > 5'd8) ? 5'd8 : 5'(flen) - start)
                                         : 5'd0;
    assign o_raddr = ngp_pkg::STORE_AW'({i_line.bank, f} * ngp_pkg::SLOT_BYTES)
                   + ngp_pkg::STORE_AW'(start + r_ci);
    assign o_busy  = r_st != ngp_pkg::BK_IDLE || i_line_valid;
    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    always_comb begin
        n_st = r_st; n_ei = r_ei; n_ci = r_ci; n_txt = r_txt; n_fix = r_fix;
        n_fdone = r_fdone; n_neg = r_neg; n_lead = r_lead; n_out = r_out; n_ov = r_ov;
        o_pop = 1'b0; nb = r_ci - 5'd1; j = nb[3:0] - 4'd0; bvalid = 1'b0;
        if (r_ov && o_res.ready) n_ov = 1'b0;
        unique case (r_st)
            ngp_pkg::BK_IDLE: begin
                if (i_line_valid) begin
                    n_ei = ok ? 4'd0 : 4'd14;
                    n_st = ok ? ngp_pkg::BK_READ : ngp_pkg::BK_EMIT;
                    n_ci = '0; n_txt = '0; n_fix = 1'b0; n_fdone = 1'b0;
                    n_neg = 1'b0; n_lead = 1'b1;
                end
            end
            ngp_pkg::BK_READ: begin
                // one byte a cycle, data arrives in the cycle after its address
                if (r_ci != '0) begin
                    bvalid = 1'b1;
                    n_txt[8*j[2:0] +: 8] = i_rdata;
                    if (f == 3'd3 && !r_fdone) begin
                        if (r_lead && (i_rdata == 8'h20 || (i_rdata >= 8'h09 && i_rdata <= 8'h0D)))
                            n_lead = 1'b1;
                        else if (r_lead && (i_rdata == 8'h2B || i_rdata == 8'h2D)) begin
                            n_lead = 1'b0; n_neg = i_rdata == 8'h2D;
                        end else if (i_rdata >= 8'h30 && i_rdata <= 8'h39) begin
                            n_lead = 1'b0;
                            if (i_rdata != 8'h30) begin n_fix = !r_neg; n_fdone = 1'b1; end
                        end else n_fdone = 1'b1;
                    end
                end
                if (r_ci == n_chars) n_st = ngp_pkg::BK_EMIT;
                else n_ci = r_ci + 5'd1;
            end
            ngp_pkg::BK_EMIT: begin
                if (!n_ov) begin
                    n_ov = 1'b1;
                    n_out = '0;
                    if (r_ei == 4'd14) begin
                        n_out.field_id = ngp_pkg::ID_SUMMARY;
                        n_out.status = i_line.status;
                        n_out.last = 1'b1;
                        if (ok) begin
                            n_out.ns_char = i_line.ns; n_out.ew_char = i_line.ew;
                            n_out.unit_char = i_line.unit; n_out.fix_valid = r_fix;
                        end
                        o_pop = 1'b1;
                        n_st = ngp_pkg::BK_IDLE;
                    end else begin
                        n_out.field_id = f;
                        n_out.chunk_index = r_ei[0];
                        n_out.chunk_text = r_txt;
                        n_out.chunk_length = n_chars[3:0];
                        n_ei = r_ei + 4'd1;
                        n_ci = '0; n_txt = '0;
                        if (r_ei[0]) begin n_fdone = r_fdone; end
                        n_st = (r_ei == 4'd13) ? ngp_pkg::BK_EMIT : ngp_pkg::BK_READ;
                    end
                end
            end
            default: n_st = ngp_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_txt <= n_txt; r_out <= n_out; r_ci <= n_ci; r_ei <= n_ei;
        r_fix <= n_fix; r_fdone <= n_fdone; r_neg <= n_neg; r_lead <= n_lead;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ngp_pkg::BK_IDLE; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_ov <= n_ov;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_res.ready |=> r_ov && $stable(r_out))
        else $error("result changed while stalled");
    a_pop_on_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_ov && r_out.last)
        else $error("line popped without summary");
    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ngp_pkg::BK_READ |-> r_ci <= 5'd8 && !bvalid || r_ci <= 5'd8)
        else $error("chunk read overran");
endmodule
`default_nettype wire

// ===== bench/nmea_gga_sentence_parser_test.sv =====
// testbench: gga sentence parser driven with directed and generated nmea lines, checked by a scoreboard
`timescale 1ns / 1ps
`default_nettype none
module nmea_gga_sentence_parser_test;

    typedef enum int {
        LN_GOOD, LN_LOWHEX, LN_BADSUM, LN_ONEDIGIT, LN_TRAIL,
        LN_NOSTAR, LN_FEW, LN_NOTGGA, LN_LONG, LN_NOISE, LN_EMPTY
    } t_line_kind;

    class gga_scoreboard;
        ngp_pkg::t_result expected_q[$];
        int         fails;
        string      hdr_txt = "$GPGGA";
        int         line_count;
        int         header_pos;
        logic [7:0] xor_sum;
        logic [7:0] sum_rx;
        bit         star_seen;
        int         hex_count;
        int         field_num;
        int         field_chars;
        logic [7:0] store [ngp_pkg::STORE_DEPTH];
        int         lengths [7];
        logic [7:0] ind [3];
        bit         cr_pending;
        bit         too_long;

        function void clear_line();
            line_count = 0; header_pos = 0; xor_sum = 0; sum_rx = 0;
            star_seen = 0; hex_count = 0; field_num = 0; field_chars = 0;
            foreach (lengths[i]) lengths[i] = 0;
            foreach (ind[i]) ind[i] = 0;
            too_long = 0;
        endfunction

        function new();
            fails = 0;
            foreach (store[i]) store[i] = 0;
            cr_pending = 0;
            clear_line();
        endfunction

        function int text_of(int f);
            case (f)
                1: return 0; 2: return 1; 4: return 2; 6: return 3;
                7: return 4; 8: return 5; 9: return 6;
                default: return -1;
            endcase
        endfunction

        function int ind_of(int f);
            case (f)
                3: return 0; 5: return 1; 10: return 2;
                default: return -1;
            endcase
        endfunction

        function int hex_val(logic [7:0] b);
            if (b >= "0" && b <= "9") return b - "0";
            if (b >= "A" && b <= "F") return b - "A" + 10;
            if (b >= "a" && b <= "f") return b - "a" + 10;
            return -1;
        endfunction

        function void take(logic [7:0] b);
            int pos;
            int ts;
            int is;
            int v;
            pos = line_count;
            if (line_count <= ngp_pkg::CONTENT_MAX) line_count++;
            if (line_count > ngp_pkg::CONTENT_MAX) too_long = 1;
            if (header_pos < 6)
                header_pos = (b == hdr_txt[header_pos]) ? header_pos + 1 : 7;
            if (!star_seen) begin
                if (b == ngp_pkg::C_STAR) begin
                    star_seen = 1;
                    return;
                end
                if (pos > 0) xor_sum ^= b;
                if (b == ngp_pkg::C_COMMA) begin
                    if (field_num < 15) field_num++;
                    field_chars = 0;
                    return;
                end
                ts = text_of(field_num);
                is = ind_of(field_num);
                if (ts >= 0 && lengths[ts] < ngp_pkg::CHARS_LIM) begin
                    store[ts * ngp_pkg::SLOT_BYTES + lengths[ts]] = b;
                    lengths[ts]++;
                end
                if (is >= 0 && field_chars == 0) ind[is] = b;
                if (field_chars < 2) field_chars++;
            end else begin
                v = hex_val(b);
                if (hex_count < 2 && v >= 0) begin
                    sum_rx = {sum_rx[3:0], 4'(v)};
                    hex_count++;
                end else begin
                    hex_count = 3;
                end
            end
        endfunction

        // atoi style: skip white space and one sign, then any nonzero digit of the leading digit run counts
        function bit fix_positive();
            int  i;
            int  base;
            bit  neg;
            base = 3 * ngp_pkg::SLOT_BYTES;
            i = 0;
            neg = 0;
            while (i < lengths[3] && (store[base+i] == " " ||
                   (store[base+i] >= 9 && store[base+i] <= 13))) i++;
            if (i < lengths[3] && (store[base+i] == "+" || store[base+i] == "-")) begin
                neg = (store[base+i] == "-");
                i++;
            end
            for (; i < lengths[3] && store[base+i] >= "0" && store[base+i] <= "9"; i++)
                if (store[base+i] != "0") return !neg;
            return 0;
        endfunction

        function void end_line();
            ngp_pkg::t_status st;
            ngp_pkg::t_result r;
            int      n;
            if (too_long) st = ngp_pkg::ST_TOO_LONG;
            else if (header_pos != 6) st = ngp_pkg::ST_NOT_GGA;
            else if (!star_seen) st = ngp_pkg::ST_NO_STAR;
            else if (hex_count != 2 || sum_rx != xor_sum) st = ngp_pkg::ST_CHECKSUM;
            else if (field_num < 10) st = ngp_pkg::ST_FEW_FIELDS;
            else st = ngp_pkg::ST_OK;
            if (st == ngp_pkg::ST_OK) begin
                for (int f = 0; f < 7; f++) begin
                    for (int c = 0; c < 2; c++) begin
                        r = '0;
                        n = lengths[f] > c * 8 ? lengths[f] - c * 8 : 0;
                        if (n > 8) n = 8;
                        for (int i = 0; i < n; i++)
                            r.chunk_text[8*i +: 8] =
                                store[f * ngp_pkg::SLOT_BYTES + c * 8 + i];
                        r.field_id = 3'(f);
                        r.chunk_index = c[0];
                        r.chunk_length = 4'(n);
                        expected_q.push_back(r);
                    end
                end
                r = '0;
                r.ns_char = ind[0];
                r.ew_char = ind[1];
                r.unit_char = ind[2];
                r.fix_valid = fix_positive();
            end else begin
                r = '0;
            end
            r.field_id = ngp_pkg::ID_SUMMARY;
            r.status = st;
            r.last = 1'b1;
            expected_q.push_back(r);
            clear_line();
        endfunction

        function void note(logic [7:0] b);
            if (cr_pending) begin
                cr_pending = 0;
                if (b == ngp_pkg::C_LF) begin
                    end_line();
                    return;
                end
                take(ngp_pkg::C_CR);
            end
            if (b == ngp_pkg::C_CR) cr_pending = 1;
            else take(b);
        endfunction

        function void check(ngp_pkg::t_result got);
            ngp_pkg::t_result want;
            if (expected_q.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected result %h", got);
                return;
            end
            want = expected_q.pop_front();
            if (got.field_id != want.field_id || got.chunk_index != want.chunk_index ||
                got.chunk_text != want.chunk_text ||
                got.chunk_length != want.chunk_length ||
                got.ns_char != want.ns_char || got.ew_char != want.ew_char ||
                got.unit_char != want.unit_char || got.fix_valid != want.fix_valid ||
                got.status != want.status || got.last != want.last) begin
                fails++;
                if (fails <= 10) begin
                    $display("mismatch id %0d/%0d chunk %0d/%0d text %h/%h len %0d/%0d",
                             got.field_id, want.field_id, got.chunk_index,
                             want.chunk_index, got.chunk_text, want.chunk_text,
                             got.chunk_length, want.chunk_length);
                    $display("  ind %h %h %h / %h %h %h fix %0d/%0d st %0d/%0d last %0d/%0d",
                             got.ns_char, got.ew_char, got.unit_char, want.ns_char,
                             want.ew_char, want.unit_char, got.fix_valid, want.fix_valid,
                             got.status, want.status, got.last, want.last);
                end
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    ngp_stream_if #(.T(logic [7:0]))        rx_if ();
    ngp_stream_if #(.T(ngp_pkg::t_result))  res_if ();

    nmea_gga_sentence_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    gga_scoreboard sb = new();
    logic [7:0]    line_q[$];
    int            results_seen = 0;
    int            ready_hold = 0;
    bit            long_stall_done = 0;
    int            bytes_sent = 0;

    function int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // result side: random back-pressure plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready = 0;
        end else if (!long_stall_done && results_seen >= 20) begin
            long_stall_done = 1;
            ready_hold = 500;
            res_if.ready = 0;
        end else if (ready_hold > 0) begin
            ready_hold--;
            res_if.ready = 0;
        end else begin
            res_if.ready = 1;
            ready_hold = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            sb.check(res_if.data);
            results_seen++;
        end
    end

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            rx_if.valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        rx_if.valid = 1;
        rx_if.data = b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        sb.note(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line();
        foreach (line_q[i]) send_byte(line_q[i]);
        line_q.delete();
    endtask

    task automatic push_str(string s);
        foreach (s[i]) line_q.push_back(s[i]);
    endtask

    function logic [7:0] hex_char(logic [3:0] v, bit lower);
        if (v < 10) return "0" + v;
        return (lower ? "a" : "A") + v - 10;
    endfunction

    // star, checksum digits and cr lf; the checksum covers everything after the dollar
    task automatic close_line(t_line_kind kind);
        logic [7:0] x;
        bit         lower;
        x = 0;
        for (int i = 1; i < line_q.size(); i++) x ^= line_q[i];
        if (kind == LN_BADSUM) x ^= 8'($urandom_range(255, 1));
        lower = (kind == LN_LOWHEX);
        line_q.push_back(ngp_pkg::C_STAR);
        line_q.push_back(hex_char(x[7:4], lower));
        if (kind != LN_ONEDIGIT) line_q.push_back(hex_char(x[3:0], lower));
        if (kind == LN_TRAIL) line_q.push_back($urandom_range(1) ? "5" : "Z");
        line_q.push_back(ngp_pkg::C_CR);
        line_q.push_back(ngp_pkg::C_LF);
    endtask

    function logic [7:0] field_byte(bit fixf);
        logic [7:0] b;
        int         p;
        string      fixset = " +-0123456789";
        p = $urandom_range(9);
        if (fixf && p < 7) return fixset[$urandom_range(fixset.len() - 1)];
        if (p < 6) return 8'("0" + $urandom_range(9));
        if (p < 8) return 8'("A" + $urandom_range(25));
        do b = 8'($urandom_range(255));
        while (b == ngp_pkg::C_COMMA || b == ngp_pkg::C_STAR || b == ngp_pkg::C_CR);
        return b;
    endfunction

    task automatic push_field(int fnum);
        int n;
        int p;
        p = $urandom_range(9);
        if (p < 6) n = $urandom_range(2);
        else if (p < 9) n = $urandom_range(8, 3);
        else n = $urandom_range(20, 9);
        repeat (n) line_q.push_back(field_byte(fnum == 6));
    endtask

    task automatic gen_line(t_line_kind kind);
        int nf;
        if (kind == LN_EMPTY) begin
            push_str("\r\n");
            return;
        end
        if (kind == LN_NOISE) begin
            repeat ($urandom_range(30)) begin
                logic [7:0] b;
                do b = 8'($urandom_range(255)); while (b == ngp_pkg::C_CR);
                line_q.push_back(b);
            end
            push_str("\r\n");
            return;
        end
        if (kind == LN_NOTGGA) push_str($urandom_range(1) ? "$GPRMC" : "$GPGG");
        else push_str("$GPGGA");
        if ($urandom_range(9) == 0) push_str("xy");
        nf = (kind == LN_FEW) ? $urandom_range(9) : $urandom_range(16, 10);
        for (int f = 1; f <= nf; f++) begin
            line_q.push_back(ngp_pkg::C_COMMA);
            if (kind == LN_LONG && f == 1) repeat (250) line_q.push_back("7");
            else push_field(f);
        end
        if (kind == LN_NOSTAR) push_str("\r\n");
        else close_line(kind);
    endtask

    function t_line_kind pick_kind();
        int p;
        p = $urandom_range(99);
        if (p < 55) return LN_GOOD;
        if (p < 62) return LN_LOWHEX;
        if (p < 68) return LN_BADSUM;
        if (p < 71) return LN_ONEDIGIT;
        if (p < 74) return LN_TRAIL;
        if (p < 78) return LN_NOSTAR;
        if (p < 83) return LN_FEW;
        if (p < 88) return LN_NOTGGA;
        if (p < 89) return LN_LONG;
        if (p < 97) return LN_NOISE;
        return LN_EMPTY;
    endfunction

    initial begin
        rx_if.valid = 0;
        rx_if.data = 0;
        res_if.ready = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: a typical sentence, an empty line, lone cr and lone lf, overlong field, signed fix, bad checksum
        push_str("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,");
        close_line(LN_GOOD);
        send_line();
        push_str("\r\n");
        send_line();
        push_str("$GPGGA,1\r2,\n,S,,W, -3,12345678901234567,,,,");
        close_line(LN_LOWHEX);
        send_line();
        push_str("$GPGGA,,,,,,+07,,,,,");
        close_line(LN_GOOD);
        send_line();
        push_str("$GPGGA,,,,,,0,,,,F,");
        close_line(LN_BADSUM);
        send_line();

        while (bytes_sent < 330) begin
            gen_line(pick_kind());
            send_line();
        end
        rx_if.valid = 0;

        wait (sb.expected_q.size() == 0);
        repeat (300) @(posedge i_clk);
        if (sb.fails == 0 && sb.expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
